// ===== hdl/sfv_pkg.sv =====
// Shared widths, register indexes and sideband types for the spring force pipeline.
package sfv_pkg;

	localparam int U_W        = 34;  // magnitude of one separation component
	localparam int H_W        = 17;  // half of a magnitude, for split products
	localparam int SQ_W       = 68;  // sum of three squares
	localparam int RAD_W      = 72;  // radicand padded to whole digit pairs
	localparam int ROOT_W     = 36;
	localparam int REM_SQ_W   = 38;
	localparam int SQRT_STEPS = 36;
	localparam int LEN_W      = 35;
	localparam int K_W        = 31;
	localparam int P_W        = 69;  // magnitude times stretch
	localparam int C_W        = 23;  // chunk of P_W for the stiffness product
	localparam int NUM_W      = 100;
	localparam int Q_W        = 32;
	localparam int DIV_STEPS  = 32;

	typedef enum logic [3:0] {
		REG_END_A_X,
		REG_END_A_Y,
		REG_END_A_Z,
		REG_END_B_X,
		REG_END_B_Y,
		REG_END_B_Z,
		REG_STIFFNESS,
		REG_REST_LENGTH
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][U_W-1:0] mag;
		logic [2:0]          sgn;
	} sfv_vec_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
		logic [2:0] ovf;
	} sfv_flags_t;

endpackage

// ===== hdl/sfv_sqrt_cell.sv =====
// One digit-pair step of the integer square root chain.
module sfv_sqrt_cell (
	input  logic                          clk,
	input  logic [sfv_pkg::REM_SQ_W-1:0]  rem_in,
	input  logic [sfv_pkg::ROOT_W-1:0]    root_in,
	input  logic [sfv_pkg::RAD_W-1:0]     rad_in,
	output logic [sfv_pkg::REM_SQ_W-1:0]  rem_q,
	output logic [sfv_pkg::ROOT_W-1:0]    root_q,
	output logic [sfv_pkg::RAD_W-1:0]     rad_q
);
	import sfv_pkg::*;

	logic [REM_SQ_W-1:0] r2;
	logic [REM_SQ_W-1:0] trial;
	logic                ge;

	always_comb begin
		r2    = {rem_in[REM_SQ_W-3:0], rad_in[RAD_W-1 -: 2]};
		trial = {root_in, 2'b01};
		ge    = (r2 >= trial);
	end

	always_ff @(posedge clk) begin
		rem_q  <= ge ? (r2 - trial) : r2;
		root_q <= {root_in[ROOT_W-2:0], ge};
		rad_q  <= {rad_in[RAD_W-3:0], 2'b00};
	end

endmodule

// ===== hdl/sfv_div_cell.sv =====
// One restoring division step for a single force component.
module sfv_div_cell #(
	parameter int DEN_W = 51
) (
	input  logic                      clk,
	input  logic [DEN_W:0]            rem_in,
	input  logic [sfv_pkg::Q_W-1:0]   quo_in,
	input  logic [sfv_pkg::Q_W-1:0]   low_in,
	input  logic [DEN_W-1:0]          denom,
	output logic [DEN_W:0]            rem_q,
	output logic [sfv_pkg::Q_W-1:0]   quo_q,
	output logic [sfv_pkg::Q_W-1:0]   low_q
);
	import sfv_pkg::*;

	localparam int REM_W = DEN_W + 1;

	logic [REM_W-1:0] r2;
	logic [REM_W-1:0] den_x;
	logic             ge;

	always_comb begin
		r2    = {rem_in[REM_W-2:0], low_in[Q_W-1]};
		den_x = REM_W'(denom);
		ge    = (r2 >= den_x);
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? (r2 - den_x) : r2;
		quo_q <= {quo_in[Q_W-2:0], ge};
		low_q <= {low_in[Q_W-2:0], 1'b0};
	end

endmodule

// ===== hdl/spring_force_vector.sv =====
// Spring force pipeline: separation, length by root chain, force by division chain.
// Takes one spring per clock whenever start is high; busy is never raised. Each
// result appears on the force ports with done high for one cycle: registered
// separation and squared-length stages, 36 root cells give the length, registered
// stretch and numerator stages, 32 division cells give the quotients and a final
// register saturates. The receiver cannot stall, so results must be taken as they
// come. Registers are written on wr_en; the user must write them only while the
// pipeline is empty, which the block itself does not enforce; indexes beyond the list are ignored.
module spring_force_vector #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [3:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] a_pos_x,
	input  logic signed [31:0] a_pos_y,
	input  logic signed [31:0] a_pos_z,
	input  logic signed [31:0] b_pos_x,
	input  logic signed [31:0] b_pos_y,
	input  logic signed [31:0] b_pos_z,
	output logic               done,
	output logic signed [31:0] force_a_x,
	output logic signed [31:0] force_a_y,
	output logic signed [31:0] force_a_z,
	output logic signed [31:0] force_b_x,
	output logic signed [31:0] force_b_y,
	output logic signed [31:0] force_b_z,
	output logic               zero_length,
	output logic               clipped
);
	import sfv_pkg::*;

	localparam int DEN_W   = LEN_W + FRAC_BITS;
	localparam int REM_W   = DEN_W + 1;
	localparam int LATENCY = 4 + SQRT_STEPS + 6 + DIV_STEPS + 1;

	// configuration
	logic signed [31:0] end_a_q [3];
	logic signed [31:0] end_b_q [3];
	logic [K_W-1:0]     stiffness_q;
	logic [K_W-1:0]     rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				end_a_q[i] <= '0;
				end_b_q[i] <= '0;
			end
			stiffness_q <= K_W'(64'd1 << FRAC_BITS);
			rest_q      <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_END_A_X:     end_a_q[0]  <= wr_data;
				REG_END_A_Y:     end_a_q[1]  <= wr_data;
				REG_END_A_Z:     end_a_q[2]  <= wr_data;
				REG_END_B_X:     end_b_q[0]  <= wr_data;
				REG_END_B_Y:     end_b_q[1]  <= wr_data;
				REG_END_B_Z:     end_b_q[2]  <= wr_data;
				REG_STIFFNESS:   stiffness_q <= wr_data[K_W-1:0];
				REG_REST_LENGTH: rest_q      <= wr_data[K_W-1:0];
				default: ;
			endcase
		end
	end

	// valid line
	logic [LATENCY-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LATENCY-1];

	// stage 1: separation
	logic signed [31:0] a_pos [3];
	logic signed [31:0] b_pos [3];
	logic signed [34:0] d_c   [3];
	sfv_vec_t           vec_s1;

	assign a_pos[0] = a_pos_x;
	assign a_pos[1] = a_pos_y;
	assign a_pos[2] = a_pos_z;
	assign b_pos[0] = b_pos_x;
	assign b_pos[1] = b_pos_y;
	assign b_pos[2] = b_pos_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = 35'(b_pos[i]) + 35'(end_b_q[i]) - 35'(a_pos[i]) - 35'(end_a_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vec_s1.mag[i] <= d_c[i][34] ? U_W'(-d_c[i]) : U_W'(d_c[i]);
			vec_s1.sgn[i] <= d_c[i][34];
		end
	end

	// stages 2..4: squared length
	logic [2*H_W-1:0] hh_s2 [3];
	logic [2*H_W-1:0] hl_s2 [3];
	logic [2*H_W-1:0] ll_s2 [3];
	sfv_vec_t         vec_s2, vec_s3, vec_s4;
	logic [SQ_W-1:0]  sq_s3 [3];
	logic [SQ_W-1:0]  rad_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s2[i] <= vec_s1.mag[i][U_W-1:H_W] * vec_s1.mag[i][U_W-1:H_W];
			hl_s2[i] <= vec_s1.mag[i][U_W-1:H_W] * vec_s1.mag[i][H_W-1:0];
			ll_s2[i] <= vec_s1.mag[i][H_W-1:0] * vec_s1.mag[i][H_W-1:0];
			sq_s3[i] <= (SQ_W'(hh_s2[i]) << (2*H_W)) + (SQ_W'(hl_s2[i]) << (H_W+1))
				+ SQ_W'(ll_s2[i]);
		end
		rad_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		vec_s2 <= vec_s1;
		vec_s3 <= vec_s2;
		vec_s4 <= vec_s3;
	end

	// root chain
	logic [REM_SQ_W-1:0] sq_rem  [0:SQRT_STEPS];
	logic [ROOT_W-1:0]   sq_root [0:SQRT_STEPS];
	logic [RAD_W-1:0]    sq_rad  [0:SQRT_STEPS];
	sfv_vec_t            sqv_q   [SQRT_STEPS];

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = RAD_W'(rad_s4);

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		sfv_sqrt_cell u_cell (
			.clk     (clk),
			.rem_in  (sq_rem[k]),
			.root_in (sq_root[k]),
			.rad_in  (sq_rad[k]),
			.rem_q   (sq_rem[k+1]),
			.root_q  (sq_root[k+1]),
			.rad_q   (sq_rad[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				sqv_q[k] <= vec_s4;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				sqv_q[k] <= sqv_q[k-1];
			end
		end
	end

	// stage 5: stretch
	logic [LEN_W-1:0] len_c;
	logic [LEN_W:0]   dl_c;
	logic [LEN_W-1:0] dmag_s5;
	logic [DEN_W-1:0] den_s5, den_s6, den_s7, den_s8, den_s9;
	sfv_flags_t       flg_s5, flg_s6, flg_s7, flg_s8, flg_s9;
	sfv_vec_t         vec_s5;

	always_comb begin
		len_c = sq_root[SQRT_STEPS][LEN_W-1:0];
		dl_c  = {1'b0, len_c} - (LEN_W+1)'(rest_q);
	end

	always_ff @(posedge clk) begin
		dmag_s5    <= dl_c[LEN_W] ? LEN_W'(-dl_c) : dl_c[LEN_W-1:0];
		den_s5     <= DEN_W'(len_c) << FRAC_BITS;
		flg_s5.zero <= (len_c == '0);
		flg_s5.neg <= sqv_q[SQRT_STEPS-1].sgn ^ {3{dl_c[LEN_W]}};
		flg_s5.ovf <= '0;
		vec_s5     <= sqv_q[SQRT_STEPS-1];
	end

	// stages 6..9: numerators
	logic [H_W+LEN_W-1:0] pl_s6 [3];
	logic [H_W+LEN_W-1:0] ph_s6 [3];
	logic [P_W-1:0]       p_s7  [3];
	logic [C_W+K_W-1:0]   c0_s8 [3];
	logic [C_W+K_W-1:0]   c1_s8 [3];
	logic [C_W+K_W-1:0]   c2_s8 [3];
	logic [NUM_W-1:0]     num_s9 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pl_s6[i]  <= vec_s5.mag[i][H_W-1:0] * dmag_s5;
			ph_s6[i]  <= vec_s5.mag[i][U_W-1:H_W] * dmag_s5;
			p_s7[i]   <= (P_W'(ph_s6[i]) << H_W) + P_W'(pl_s6[i]);
			c0_s8[i]  <= p_s7[i][C_W-1:0] * stiffness_q;
			c1_s8[i]  <= p_s7[i][2*C_W-1:C_W] * stiffness_q;
			c2_s8[i]  <= p_s7[i][3*C_W-1:2*C_W] * stiffness_q;
			num_s9[i] <= (NUM_W'(c2_s8[i]) << (2*C_W)) + (NUM_W'(c1_s8[i]) << C_W)
				+ NUM_W'(c0_s8[i]);
		end
		den_s6 <= den_s5;
		den_s7 <= den_s6;
		den_s8 <= den_s7;
		den_s9 <= den_s8;
		flg_s6 <= flg_s5;
		flg_s7 <= flg_s6;
		flg_s8 <= flg_s7;
		flg_s9 <= flg_s8;
	end

	// stage 10: overflow check and division set-up
	logic [REM_W-1:0] rem_s10 [3];
	logic [Q_W-1:0]   low_s10 [3];
	logic [DEN_W-1:0] den_s10;
	sfv_flags_t       flg_s10;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			flg_s10.ovf[i] <= (num_s9[i][NUM_W-1:Q_W] >= (NUM_W-Q_W)'(den_s9));
			rem_s10[i]     <= num_s9[i][Q_W +: REM_W];
			low_s10[i]     <= num_s9[i][Q_W-1:0];
		end
		flg_s10.zero <= flg_s9.zero;
		flg_s10.neg  <= flg_s9.neg;
		den_s10      <= den_s9;
	end

	// division chain
	logic [REM_W-1:0] dv_rem [0:DIV_STEPS][3];
	logic [Q_W-1:0]   dv_quo [0:DIV_STEPS][3];
	logic [Q_W-1:0]   dv_low [0:DIV_STEPS][3];
	logic [DEN_W-1:0] dvd_q  [DIV_STEPS];
	sfv_flags_t       dvf_q  [DIV_STEPS];

	for (genvar i = 0; i < 3; i++) begin : g_lane_init
		assign dv_rem[0][i] = rem_s10[i];
		assign dv_quo[0][i] = '0;
		assign dv_low[0][i] = low_s10[i];
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		for (genvar i = 0; i < 3; i++) begin : g_lane
			sfv_div_cell #(.DEN_W(DEN_W)) u_cell (
				.clk    (clk),
				.rem_in (dv_rem[k][i]),
				.quo_in (dv_quo[k][i]),
				.low_in (dv_low[k][i]),
				.denom  ((k == 0) ? den_s10 : dvd_q[(k == 0) ? 0 : k-1]),
				.rem_q  (dv_rem[k+1][i]),
				.quo_q  (dv_quo[k+1][i]),
				.low_q  (dv_low[k+1][i])
			);
		end
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				dvd_q[k] <= den_s10;
				dvf_q[k] <= flg_s10;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				dvd_q[k] <= dvd_q[k-1];
				dvf_q[k] <= dvf_q[k-1];
			end
		end
	end

	// final stage: sign and saturation
	logic [31:0] fa_c [3];
	logic [31:0] fb_c [3];
	logic        clip_c;
	logic [Q_W-1:0] q_c [3];
	sfv_flags_t  flg_c;
	logic [31:0] fa_q [3];
	logic [31:0] fb_q [3];
	logic        zl_q;
	logic        clip_q;

	always_comb begin
		flg_c  = dvf_q[DIV_STEPS-1];
		clip_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			q_c[i] = dv_quo[DIV_STEPS][i];
			fa_c[i] = '0;
			fb_c[i] = '0;
			if (!flg_c.zero) begin
				if (flg_c.neg[i]) begin
					if (flg_c.ovf[i] || (q_c[i] > 32'h8000_0000)) begin
						fa_c[i] = 32'h8000_0000;
						clip_c  = 1'b1;
					end else begin
						fa_c[i] = -q_c[i];
					end
				end else begin
					if (flg_c.ovf[i] || q_c[i][Q_W-1]) begin
						fa_c[i] = 32'h7FFF_FFFF;
						clip_c  = 1'b1;
					end else begin
						fa_c[i] = q_c[i];
					end
				end
				// negating the most negative value cannot be held: clamp
				if (fa_c[i] == 32'h8000_0000) begin
					fb_c[i] = 32'h7FFF_FFFF;
					clip_c  = 1'b1;
				end else begin
					fb_c[i] = -fa_c[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			fa_q[i] <= fa_c[i];
			fb_q[i] <= fb_c[i];
		end
		zl_q   <= flg_c.zero;
		clip_q <= clip_c;
	end

	assign force_a_x   = fa_q[0];
	assign force_a_y   = fa_q[1];
	assign force_a_z   = fa_q[2];
	assign force_b_x   = fb_q[0];
	assign force_b_y   = fb_q[1];
	assign force_b_z   = fb_q[2];
	assign zero_length = zl_q;
	assign clipped     = clip_q;

	a_zero_forces: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_length |-> force_a_x == 0 && force_a_y == 0 && force_a_z == 0
			&& force_b_x == 0 && force_b_y == 0 && force_b_z == 0 && !clipped)
		else $error("forces not cleared for coincident endpoints");

	a_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		done && !clipped |-> force_b_x == -force_a_x && force_b_y == -force_a_y
			&& force_b_z == -force_a_z)
		else $error("force on B is not the negation of force on A");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##(LATENCY-1) done)
		else $error("result beat missing after pipeline latency");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, LATENCY) |-> !done || $past(!arst_n, LATENCY))
		else $error("result beat without a matching start");

endmodule

// ===== tb/spring_checker.sv =====
// Checker for the spring force pipeline: register copy, force prediction and result compare.
`timescale 1ns / 100ps
module spring_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [3:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] a_pos_x,
	input  logic [31:0] a_pos_y,
	input  logic [31:0] a_pos_z,
	input  logic [31:0] b_pos_x,
	input  logic [31:0] b_pos_y,
	input  logic [31:0] b_pos_z,
	input  logic        done,
	input  logic [31:0] force_a_x,
	input  logic [31:0] force_a_y,
	input  logic [31:0] force_a_z,
	input  logic [31:0] force_b_x,
	input  logic [31:0] force_b_y,
	input  logic [31:0] force_b_z,
	input  logic        zero_length,
	input  logic        clipped,
	output int          fails,
	output int          pending
);
	import sfv_pkg::*;

	typedef struct packed {
		logic [2:0][31:0] fa;
		logic [2:0][31:0] fb;
		logic             zero;
		logic             clip;
	} spring_force_t;

	logic [2:0][31:0] end_a, end_b;
	logic [30:0]      stiffness, rest_length;
	spring_force_t    force_queue[$];

	function automatic spring_force_t predict_spring(logic [2:0][31:0] pa, logic [2:0][31:0] pb);
		spring_force_t     r;
		logic signed [33:0] d[3];
		logic [33:0]        u[3];
		logic [67:0]        s;
		logic [35:0]        len, t;
		logic [71:0]        sq;
		logic signed [37:0] delta;
		logic [37:0]        dmag;
		logic [127:0]       num, den, q;
		logic               dneg, neg;
		logic signed [32:0] fa;
		s = '0;
		len = '0;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = $signed({{2{pb[i][31]}}, pb[i]}) + $signed({{2{end_b[i][31]}}, end_b[i]})
				- $signed({{2{pa[i][31]}}, pa[i]}) - $signed({{2{end_a[i][31]}}, end_a[i]});
			u[i] = d[i][33] ? -d[i] : d[i];
			s = s + {34'd0, u[i]} * {34'd0, u[i]};
		end
		for (int b = 35; b >= 0; b--) begin
			t = len | (36'd1 << b);
			sq = {36'd0, t} * {36'd0, t};
			if (sq <= {4'd0, s})
				len = t;
		end
		if (len == 0) begin
			r.zero = 1'b1;
			return r;
		end
		delta = $signed({2'b0, len}) - $signed({7'b0, rest_length});
		dneg = delta[37];
		dmag = dneg ? -delta : delta;
		den = {92'd0, len} << FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			num = {94'd0, u[i]} * {90'd0, dmag} * {97'd0, stiffness};
			q = num / den;
			neg = dneg != d[i][33];
			if (neg) begin
				if (q > 128'h8000_0000) begin
					fa = -33'sd2147483648;
					r.clip = 1'b1;
				end else
					fa = -$signed({1'b0, q[31:0]});
			end else begin
				if (q > 128'h7FFF_FFFF) begin
					fa = 33'sd2147483647;
					r.clip = 1'b1;
				end else
					fa = $signed({1'b0, q[31:0]});
			end
			r.fa[i] = fa[31:0];
			// the most negative force has no positive twin: clip B's copy
			if (fa == -33'sd2147483648) begin
				r.fb[i] = 32'h7FFF_FFFF;
				r.clip = 1'b1;
			end else
				r.fb[i] = -fa[31:0];
		end
		return r;
	endfunction

	assign pending = force_queue.size();

	always @(posedge clk or negedge arst_n) begin
		spring_force_t want, got;
		if (!arst_n) begin
			end_a <= '0;
			end_b <= '0;
			stiffness <= 31'h1 << FRAC_BITS;
			rest_length <= '0;
			fails <= 0;
			force_queue.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_END_A_X:     end_a[0] <= wr_data;
					REG_END_A_Y:     end_a[1] <= wr_data;
					REG_END_A_Z:     end_a[2] <= wr_data;
					REG_END_B_X:     end_b[0] <= wr_data;
					REG_END_B_Y:     end_b[1] <= wr_data;
					REG_END_B_Z:     end_b[2] <= wr_data;
					REG_STIFFNESS:   stiffness <= wr_data[30:0];
					REG_REST_LENGTH: rest_length <= wr_data[30:0];
					default: ;
				endcase
			end
			if (done) begin
				got.fa = {force_a_z, force_a_y, force_a_x};
				got.fb = {force_b_z, force_b_y, force_b_x};
				got.zero = zero_length;
				got.clip = clipped;
				if (force_queue.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, got);
					fails <= fails + 1;
				end else begin
					want = force_queue.pop_front();
					if (got !== want) begin
						$display("%0t: force mismatch expected fa=%h fb=%h zero=%b clip=%b",
							$time, want.fa, want.fb, want.zero, want.clip);
						$display("%0t:                  actual fa=%h fb=%h zero=%b clip=%b",
							$time, got.fa, got.fb, got.zero, got.clip);
						fails <= fails + 1;
					end
				end
			end
			if (start && !busy)
				force_queue.push_back(predict_spring({a_pos_z, a_pos_y, a_pos_x},
					{b_pos_z, b_pos_y, b_pos_x}));
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the spring force pipeline.
`timescale 1ns / 100ps
module testbench;
	import sfv_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int FRAC_BITS   = 16;

	logic        clk, arst_n;
	logic        wr_en;
	logic [3:0]  wr_index;
	logic [31:0] wr_data;
	logic        start, busy, done;
	logic signed [31:0] a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z;
	logic signed [31:0] force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z;
	logic        zero_length, clipped;
	int          fails, pending, cycles;
	int          idle_pct;
	logic [2:0][31:0] cur_ea, cur_eb;

	spring_force_vector #(.FRAC_BITS(FRAC_BITS)) dut (.*);

	spring_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// one beat; idle first at the current rate
	task automatic send_spring(logic [31:0] ax, ay, az, bx, by, bz);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		a_pos_x <= ax; a_pos_y <= ay; a_pos_z <= az;
		b_pos_x <= bx; b_pos_y <= by; b_pos_z <= bz;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// drain, then load every register plus one ignored index
	task automatic load_spring(logic [2:0][31:0] ea, eb, logic [31:0] k, rest);
		logic [31:0] vals[8];
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (90) @(posedge clk);
		vals = '{ea[0], ea[1], ea[2], eb[0], eb[1], eb[2], k, rest};
		cur_ea = ea;
		cur_eb = eb;
		for (int i = 0; i < 8; i++) begin
			wr_en <= 1'b1;
			wr_index <= cfg_reg_t'(i);
			wr_data <= vals[i];
			@(posedge clk);
		end
		wr_index <= 4'd8 + 4'($urandom_range(7));
		wr_data <= $urandom;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_springs(int n);
		logic [31:0] a[3], b[3];
		int mode;
		for (int j = 0; j < n; j++) begin
			mode = $urandom_range(99);
			for (int i = 0; i < 3; i++) begin
				a[i] = $urandom;
				if (mode < 5)
					b[i] = a[i] + cur_ea[i] - cur_eb[i];
				else if (mode < 55)
					b[i] = a[i] + cur_ea[i] - cur_eb[i] + $urandom_range(1 << 21) - (1 << 20);
				else if (mode < 75)
					b[i] = a[i] + cur_ea[i] - cur_eb[i] + $urandom_range(600) - 300;
				else
					b[i] = $urandom;
			end
			send_spring(a[0], a[1], a[2], b[0], b[1], b[2]);
		end
	endtask

	initial begin
		logic [2:0][31:0] zero3, maxv, minv, rnd_a, rnd_b;
		cycles = 0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		start = 1'b0;
		{a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z} = '0;
		zero3 = '0;
		maxv = {3{32'h7FFF_FFFF}};
		minv = {3{32'h8000_0000}};
		cur_ea = '0;
		cur_eb = '0;
		idle_pct = 8;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: coincident, unit, extremes, a length of five
		send_spring(0, 0, 0, 0, 0, 0);
		send_spring(5, -7, 9, 5, -7, 9);
		send_spring(0, 0, 0, 32'h0001_0000, 0, 0);
		send_spring(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_spring(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_spring(32'hFFFF_FFFF, 1, 32'h8000_0000, 0, 0, 0);
		send_spring(0, 0, 0, 0, 32'h0003_0000, 32'hFFFC_0000);
		random_springs(200);

		load_spring(zero3, zero3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_spring(0, 0, 0, 1, 0, 0);
		send_spring(0, 0, 0, 0, 0, 32'h0001_0000);
		send_spring(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
		send_spring(0, 0, 0, 0, 0, 0);
		random_springs(200);

		idle_pct = 68;
		load_spring(maxv, minv, 0, 0);
		send_spring(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_spring(0, 0, 0, 0, 0, 0);
		random_springs(150);

		load_spring(minv, maxv, 32'h7FFF_FFFF, 0);
		send_spring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_spring(0, 0, 0, 0, 0, 0);
		random_springs(150);

		idle_pct = 0;
		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < 3; i++) begin
				rnd_a[i] = (p == 0) ? $urandom : $urandom_range(1 << 22) - (1 << 21);
				rnd_b[i] = (p == 0) ? $urandom : $urandom_range(1 << 22) - (1 << 21);
			end
			load_spring(rnd_a, rnd_b, $urandom_range(32'h0004_0000),
				$urandom_range(32'h0010_0000));
			random_springs(200);
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
